/* rtl/s2i_pkg.sv */
// Shared types and constants for the streaming string-to-int64 parser.
// Used by the front end, the parse engine, the result queue and the top level.
// No dependencies.
package s2i_pkg;

	// Position saturates here; end indexes are 16 bits wide.
	localparam int unsigned POS_W     = 16;
	localparam logic [POS_W-1:0] MAX_INDEX = 16'hFFFF;

	// Radix register width and the bases that have special meaning.
	localparam int unsigned RADIX_W   = 6;
	localparam logic [RADIX_W-1:0] RADIX_AUTO = 6'd0;
	localparam logic [RADIX_W-1:0] RADIX_ONE  = 6'd1;
	localparam logic [RADIX_W-1:0] BASE_OCT   = 6'd8;
	localparam logic [RADIX_W-1:0] BASE_DEC   = 6'd10;
	localparam logic [RADIX_W-1:0] BASE_HEX   = 6'd16;
	localparam logic [RADIX_W-1:0] BASE_MAX   = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_RESET = BASE_DEC;

	// Digit code of a character that is no digit at all; above every legal base.
	localparam logic [RADIX_W-1:0] DIGIT_NONE = 6'h3F;

	// Input queue between the front end and the parse engine.
	localparam int unsigned FQ_DEPTH = 2;
	localparam int unsigned FQ_AW    = 1;

	// Result queue.
	localparam int unsigned OQ_DEPTH = 2;
	localparam int unsigned OQ_AW    = 1;

	// Signed 64-bit limits as raw magnitudes.
	localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] INT64_MIN = 64'h8000_0000_0000_0000;

	// One classified character as it travels from the front end to the engine.
	typedef struct packed {
		logic               first;
		logic [RADIX_W-1:0] dv;
		logic               blank;
		logic               plus;
		logic               minus;
		logic               is_x;
	} item_t;

	// One conversion result.
	typedef struct packed {
		logic [63:0]      value;
		logic [POS_W-1:0] end_index;
		logic             range_error;
		logic             no_digits;
	} result_t;

	// Parser phases, one-hot.
	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_LEAD   = 7'b0000010,
		ST_SIGNED = 7'b0000100,
		ST_ZERO   = 7'b0001000,
		ST_PREFIX = 7'b0010000,
		ST_DIGITS = 7'b0100000,
		ST_DONE   = 7'b1000000
	} phase_t;

endpackage

/* rtl/s2i_front.sv */
// Front end: classifies each incoming character and holds it in a short queue.
// Depends on s2i_pkg for item_t and the queue constants.
module s2i_front
	import s2i_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  ch,
	input  logic        first,
	output logic        head_valid,
	output item_t       head,
	input  logic        head_pop
);

	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] TEN      = 8'd10;

	item_t              cls;
	logic [7:0]         dv8;
	item_t              mem_q [FQ_DEPTH];
	logic [FQ_AW-1:0]   wr_ptr_q;
	logic [FQ_AW-1:0]   rd_ptr_q;
	logic [FQ_AW:0]     count_q;
	logic               wr_en;

	// Character classification: digit value and the few special characters.
	always_comb begin
		if (ch >= CH_0 && ch <= CH_9) begin
			dv8 = ch - CH_0;
		end else if (ch >= CH_LA && ch <= CH_LZ) begin
			dv8 = ch - CH_LA + TEN;
		end else if (ch >= CH_UA && ch <= CH_UZ) begin
			dv8 = ch - CH_UA + TEN;
		end else begin
			dv8 = {2'b00, DIGIT_NONE};
		end
		cls.first = first;
		cls.dv    = dv8[RADIX_W-1:0];
		cls.blank = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
		cls.plus  = (ch == CH_PLUS);
		cls.minus = (ch == CH_MINUS);
		cls.is_x  = (ch == CH_LX) || (ch == CH_UX);
	end

	assign full       = (count_q == (FQ_AW+1)'(FQ_DEPTH));
	assign wr_en      = push && !full;
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (head_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, head_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/s2i_back.sv */
// Parse engine: runs the per-string phase machine and the digit multiply-accumulate.
// Depends on s2i_pkg for item_t, result_t, phase_t and the base constants.
module s2i_back
	import s2i_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [RADIX_W-1:0] radix,
	input  logic               item_valid,
	input  item_t              item,
	output logic               item_pop,
	input  logic               res_full,
	output logic               res_valid,
	output result_t            res
);

	localparam int unsigned MW = 64 + RADIX_W + 1;

	phase_t             phase_q;
	logic [63:0]        acc_q;
	logic               neg_q;
	logic [RADIX_W-1:0] base_q;
	logic               ovf_q;
	logic [POS_W-1:0]   pos_q;

	logic               go;
	logic               active;
	phase_t             cur_phase;
	logic [63:0]        cur_acc;
	logic               cur_neg;
	logic [RADIX_W-1:0] cur_base;
	logic               cur_ovf;
	logic [POS_W-1:0]   cur_pos;
	phase_t             nxt_phase;
	logic               nxt_neg;
	logic [RADIX_W-1:0] nxt_base;
	logic               do_acc;
	logic               begin_num;
	logic               dstep;
	logic               emit;
	logic               auto_zero;
	logic [RADIX_W-1:0] zero_base;
	logic [RADIX_W-1:0] eff_base;
	logic [MW-1:0]      prod;
	logic [63:0]        lim;
	logic               acc_ovf;
	logic [63:0]        fin_value;
	logic [POS_W-1:0]   pos_next;

	// The engine takes an item only when a result slot is free.
	assign go       = item_valid && !res_full;
	assign item_pop = go;

	// A first flag restarts the string with cleared state.
	always_comb begin
		cur_phase = item.first ? ST_LEAD : phase_q;
		cur_acc   = item.first ? '0 : acc_q;
		cur_neg   = item.first ? 1'b0 : neg_q;
		cur_base  = item.first ? '0 : base_q;
		cur_ovf   = item.first ? 1'b0 : ovf_q;
		cur_pos   = item.first ? '0 : pos_q;
		active    = item.first || !(phase_q == ST_IDLE || phase_q == ST_DONE);
	end

	// Base selection at the start of the number.
	always_comb begin
		auto_zero = (radix == RADIX_AUTO || radix == BASE_HEX) && (item.dv == '0);
		zero_base = (radix == RADIX_AUTO) ? BASE_OCT : BASE_HEX;
		if (radix == RADIX_AUTO) begin
			eff_base = BASE_DEC;
		end else if (radix == RADIX_ONE || radix > BASE_MAX) begin
			eff_base = '0;
		end else begin
			eff_base = radix;
		end
	end

	// Finished value: saturated on overflow, negated for a minus sign.
	always_comb begin
		if (cur_ovf) begin
			fin_value = cur_neg ? INT64_MIN : INT64_MAX;
		end else begin
			fin_value = cur_neg ? (64'd0 - cur_acc) : cur_acc;
		end
	end

	// Phase machine.
	always_comb begin
		nxt_phase = cur_phase;
		nxt_neg   = cur_neg;
		nxt_base  = cur_base;
		do_acc    = 1'b0;
		begin_num = 1'b0;
		dstep     = 1'b0;
		emit      = 1'b0;
		res       = '0;
		unique case (cur_phase)
			ST_LEAD: begin
				if (item.blank) begin
					nxt_phase = ST_LEAD;
				end else if (item.plus || item.minus) begin
					nxt_neg   = item.minus;
					nxt_phase = ST_SIGNED;
				end else begin
					begin_num = 1'b1;
				end
			end
			ST_SIGNED: begin
				begin_num = 1'b1;
			end
			ST_ZERO: begin
				if (item.is_x) begin
					nxt_base  = BASE_HEX;
					nxt_phase = ST_PREFIX;
				end else begin
					dstep = 1'b1;
				end
			end
			ST_PREFIX: begin
				if (item.dv < BASE_HEX) begin
					nxt_base  = BASE_HEX;
					do_acc    = 1'b1;
					nxt_phase = ST_DIGITS;
				end else begin
					// Only the leading zero converted; the end sits on the x.
					emit          = 1'b1;
					res.end_index = (cur_pos != '0) ? cur_pos - 1'b1 : '0;
				end
			end
			ST_DIGITS: begin
				dstep = 1'b1;
			end
			ST_IDLE, ST_DONE: begin
				nxt_phase = cur_phase;
			end
			default: begin
				nxt_phase = cur_phase;
			end
		endcase

		if (begin_num) begin
			if (auto_zero) begin
				nxt_base  = zero_base;
				do_acc    = 1'b1;
				nxt_phase = ST_ZERO;
			end else begin
				nxt_base = eff_base;
				if (item.dv < eff_base) begin
					do_acc    = 1'b1;
					nxt_phase = ST_DIGITS;
				end else begin
					emit          = 1'b1;
					res.no_digits = 1'b1;
				end
			end
		end

		if (dstep) begin
			if (item.dv < cur_base) begin
				do_acc    = 1'b1;
				nxt_phase = ST_DIGITS;
			end else begin
				emit            = 1'b1;
				res.value       = fin_value;
				res.end_index   = cur_pos;
				res.range_error = cur_ovf;
			end
		end

		if (emit) begin
			nxt_phase = ST_DONE;
		end
	end

	// Digit accumulate; overflow when the exact product passes the signed limit.
	always_comb begin
		prod    = MW'(cur_acc) * MW'(nxt_base) + MW'(item.dv);
		lim     = nxt_neg ? INT64_MIN : INT64_MAX;
		acc_ovf = prod > MW'(lim);
	end

	assign pos_next  = (cur_pos < MAX_INDEX) ? cur_pos + 1'b1 : cur_pos;
	assign res_valid = go && active && emit;

	// Engine state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ST_IDLE;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			base_q  <= '0;
			ovf_q   <= 1'b0;
			pos_q   <= '0;
		end else if (go && active) begin
			phase_q <= nxt_phase;
			acc_q   <= do_acc ? prod[63:0] : cur_acc;
			ovf_q   <= cur_ovf || (do_acc && acc_ovf);
			neg_q   <= nxt_neg;
			base_q  <= nxt_base;
			pos_q   <= pos_next;
		end
	end

endmodule

/* rtl/s2i_outq.sv */
// Result queue: holds finished conversions until the consumer pops them.
// Depends on s2i_pkg for result_t and the queue constants.
module s2i_outq
	import s2i_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr_en,
	input  result_t wr_data,
	output logic    full,
	output logic    empty,
	input  logic    pop,
	output result_t rd_data
);

	result_t          mem_q [OQ_DEPTH];
	logic [OQ_AW-1:0] wr_ptr_q;
	logic [OQ_AW-1:0] rd_ptr_q;
	logic [OQ_AW:0]   count_q;
	logic             rd_en;

	assign full    = (count_q == (OQ_AW+1)'(OQ_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_en   = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Result storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/string_to_int64_parser_top.sv */
// Streaming string to signed 64-bit integer parser, one character per transfer.
// Throughput: one character, one multiply-accumulate per cycle while result space is free.
// Result path: each character is registered in the input queue; the engine takes it
// from there and registers any result in the result queue, which drives the outputs.
// Reset: arst_n clears both queues and puts the parser in idle; radix resets to 10.
// Depends on s2i_pkg, s2i_front, s2i_back and s2i_outq.
module string_to_int64_parser_top
	import s2i_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [7:0]          ch,
	input  logic                first,
	output logic                empty,
	input  logic                pop,
	output logic signed [63:0]  value,
	output logic [POS_W-1:0]    end_index,
	output logic                range_error,
	output logic                no_digits,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [RADIX_W-1:0]  cfg_data
);

	logic [RADIX_W-1:0] radix_q;
	logic               fq_valid;
	item_t              fq_head;
	logic               fq_pop;
	logic               oq_full;
	logic               res_valid;
	result_t            res;
	result_t            oq_data;

	// Radix register; always ready for a transfer.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			radix_q <= cfg_data;
		end
	end

	s2i_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.ch         (ch),
		.first      (first),
		.head_valid (fq_valid),
		.head       (fq_head),
		.head_pop   (fq_pop)
	);

	s2i_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.radix      (radix_q),
		.item_valid (fq_valid),
		.item       (fq_head),
		.item_pop   (fq_pop),
		.res_full   (oq_full),
		.res_valid  (res_valid),
		.res        (res)
	);

	s2i_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_valid),
		.wr_data (res),
		.full    (oq_full),
		.empty   (empty),
		.pop     (pop),
		.rd_data (oq_data)
	);

	assign value       = oq_data.value;
	assign end_index   = oq_data.end_index;
	assign range_error = oq_data.range_error;
	assign no_digits   = oq_data.no_digits;

	// A result is never written into a full result queue.
	assert property (@(posedge clk) disable iff (!arst_n) res_valid |-> !oq_full)
		else $error("result written into full result queue");

	// The engine never stalls while it has an item and result space.
	assert property (@(posedge clk) disable iff (!arst_n) (fq_valid && !oq_full) |-> fq_pop)
		else $error("engine stalled with room for a result");

	// A failed conversion reports zero value and zero end index.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && no_digits) |-> (value == 64'sd0 && end_index == '0 && !range_error))
		else $error("no-digit result carries nonzero fields");

	// A range error always comes with a saturated value.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && range_error) |-> (value == $signed(INT64_MAX) || value == $signed(INT64_MIN)))
		else $error("range error without saturated value");

endmodule

/* verif/tb_string_to_int64_parser_top.sv */
// Self-checking testbench for the streaming string to signed 64-bit integer parser.
// Drives characters and radix settings with random idling and checks every result.
// Depends on s2i_pkg and string_to_int64_parser_top.
`timescale 1ns / 1ps

module tb_string_to_int64_parser_top;
	import s2i_pkg::*;

	// One character as it is offered to the block.
	typedef struct packed {
		logic       first;
		logic [7:0] c;
	} char_t;

	// Tracks the parse of the character stream and holds the results still owed.
	class parse_tracker;
		bit [RADIX_W-1:0] radix;
		phase_t           ph;
		bit [63:0]        acc;
		bit               neg;
		bit [RADIX_W-1:0] base;
		bit               ovf;
		bit [POS_W-1:0]   pos;
		bit               got_digit;
		result_t          pending_results[$];
		int               errors;

		function new();
			radix = RADIX_RESET;
			ph = ST_IDLE;
			errors = 0;
			restart();
		endfunction

		function void restart();
			acc = '0;
			neg = 1'b0;
			base = '0;
			ovf = 1'b0;
			pos = '0;
			got_digit = 1'b0;
		endfunction

		// Digit weight of a character, or a value above every base if it is none.
		function int char_weight(bit [7:0] c);
			if (c >= "0" && c <= "9") return c - "0";
			if (c >= "a" && c <= "z") return c - "a" + 10;
			if (c >= "A" && c <= "Z") return c - "A" + 10;
			return 255;
		endfunction

		function bit is_blank(bit [7:0] c);
			return c == " " || (c >= "\t" && c <= "\r");
		endfunction

		// Multiply-accumulate with the overflow test done before the wrap.
		function void add_digit(int dv);
			bit [63:0] lim, b, cut, rem;
			lim = neg ? INT64_MIN : INT64_MAX;
			b = (base != '0) ? 64'(base) : 64'd1;
			cut = lim / b;
			rem = lim % b;
			if (acc > cut || (acc == cut && 64'(dv) > rem))
				ovf = 1'b1;
			acc = acc * b + 64'(dv);
			got_digit = 1'b1;
		endfunction

		function void post(logic [63:0] v, logic [POS_W-1:0] e, logic re, logic nd);
			result_t r;
			r.value = v;
			r.end_index = e;
			r.range_error = re;
			r.no_digits = nd;
			pending_results.push_back(r);
			ph = ST_DONE;
		endfunction

		function void close_number();
			bit [63:0] v;
			if (ovf)
				v = neg ? INT64_MIN : INT64_MAX;
			else
				v = neg ? 64'd0 - acc : acc;
			post(v, pos, ovf, 1'b0);
		endfunction

		function void next_digit(bit [7:0] c);
			int dv;
			dv = char_weight(c);
			if (dv < base) begin
				add_digit(dv);
				ph = ST_DIGITS;
			end else begin
				close_number();
			end
		endfunction

		// First character after blanks and sign: settles the base.
		function void open_number(bit [7:0] c);
			bit [RADIX_W-1:0] b;
			b = radix;
			if ((b == RADIX_AUTO || b == BASE_HEX) && c == "0") begin
				base = (b == RADIX_AUTO) ? BASE_OCT : BASE_HEX;
				add_digit(0);
				ph = ST_ZERO;
				return;
			end
			if (b == RADIX_AUTO) b = BASE_DEC;
			if (b == RADIX_ONE || b > BASE_MAX) b = '0;
			base = b;
			if (char_weight(c) < base) begin
				add_digit(char_weight(c));
				ph = ST_DIGITS;
			end else begin
				post('0, '0, 1'b0, 1'b1);
			end
		endfunction

		// Notes one accepted character and queues any result it causes.
		function void take_char(bit [7:0] c, bit f);
			if (f) begin
				restart();
				ph = ST_LEAD;
			end else if (ph == ST_IDLE || ph == ST_DONE) begin
				return;
			end
			case (ph)
				ST_LEAD: begin
					if (!is_blank(c)) begin
						if (c == "+" || c == "-") begin
							neg = (c == "-");
							ph = ST_SIGNED;
						end else begin
							open_number(c);
						end
					end
				end
				ST_SIGNED: open_number(c);
				ST_ZERO: begin
					if (c == "x" || c == "X") begin
						base = BASE_HEX;
						ph = ST_PREFIX;
					end else begin
						next_digit(c);
					end
				end
				ST_PREFIX: begin
					// Only the leading zero was converted; the end points at the x.
					if (char_weight(c) < BASE_HEX) begin
						add_digit(char_weight(c));
						ph = ST_DIGITS;
					end else begin
						post('0, (pos > '0) ? pos - 1'b1 : '0, 1'b0, 1'b0);
					end
				end
				default: next_digit(c);
			endcase
			if (pos < MAX_INDEX) pos++;
		endfunction

		task report(string field, logic [63:0] got, logic [63:0] want);
			$display("[%0t] %s differs: got 0x%0h, expected 0x%0h", $time, field, got, want);
			errors++;
		endtask

		// Compares one transferred result with the oldest one owed.
		task match_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				report("result with none owed, value", got.value, '0);
				return;
			end
			want = pending_results.pop_front();
			if (got.value !== want.value) report("value", got.value, want.value);
			if (got.end_index !== want.end_index)
				report("end_index", got.end_index, want.end_index);
			if (got.range_error !== want.range_error)
				report("range_error", got.range_error, want.range_error);
			if (got.no_digits !== want.no_digits)
				report("no_digits", got.no_digits, want.no_digits);
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                push;
	logic                full;
	logic [7:0]          ch;
	logic                first;
	logic                empty;
	logic                pop;
	logic signed [63:0]  value;
	logic [POS_W-1:0]    end_index;
	logic                range_error;
	logic                no_digits;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [RADIX_W-1:0]  cfg_data;

	parse_tracker tracker;
	char_t        text[$];
	bit           steady;

	string_to_int64_parser_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.ch          (ch),
		.first       (first),
		.empty       (empty),
		.pop         (pop),
		.value       (value),
		.end_index   (end_index),
		.range_error (range_error),
		.no_digits   (no_digits),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	// 12 ns clock.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Idles with a chance of roughly 19 in a hundred, except during a steady stretch.
	function automatic bit take_break();
		return !steady && ($urandom_range(99) < 19);
	endfunction

	// Result side: stall at random, check every transfer.
	always @(negedge clk) begin
		pop <= !take_break();
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			tracker.match_result({value, end_index, range_error, no_digits});
	end

	function automatic void put(bit [7:0] c, bit f);
		text.push_back('{first: f, c: c});
	endfunction

	function automatic void put_str(string s, bit lead);
		for (int i = 0; i < s.len(); i++)
			put(s[i], lead && i == 0);
	endfunction

	function automatic bit [7:0] digit_char(int dv);
		if (dv < 10) return 8'("0" + dv);
		return $urandom_range(1) ? 8'("a" + dv - 10) : 8'("A" + dv - 10);
	endfunction

	// Builds one string: mostly well-formed with random content, some noise,
	// some with the terminator missing so that the next first flag cuts it off.
	function automatic void make_string(bit [RADIX_W-1:0] rdx);
		string     blanks;
		int        base, n, nd, sgn;
		bit        lead, neg;
		bit [63:0] m, lim;
		int        digs[$];

		blanks = "\t\n\v\f\r ";
		lead = 1'b1;
		if ($urandom_range(99) < 15) begin
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++)
				put(8'($urandom_range(255)), i == 0);
			return;
		end
		if (rdx >= 2 && rdx <= BASE_MAX)
			base = int'(rdx);
		else if (rdx == RADIX_AUTO)
			base = int'(($urandom_range(2) == 0) ? BASE_OCT :
				($urandom_range(1) ? BASE_DEC : BASE_HEX));
		else
			base = int'(BASE_DEC);

		n = $urandom_range(0, 2);
		for (int i = 0; i < n; i++) begin
			put(blanks[$urandom_range(5)], lead);
			lead = 1'b0;
		end
		sgn = $urandom_range(2);
		neg = (sgn == 2);
		if (sgn != 0) begin
			put(neg ? "-" : "+", lead);
			lead = 1'b0;
		end
		if (base == BASE_HEX && (rdx == RADIX_AUTO || rdx == BASE_HEX) &&
				$urandom_range(2) != 0) begin
			put("0", lead);
			put($urandom_range(1) ? "x" : "X", 1'b0);
			lead = 1'b0;
		end else if (base == BASE_OCT && rdx == RADIX_AUTO) begin
			put("0", lead);
			lead = 1'b0;
		end

		lim = neg ? INT64_MIN : INT64_MAX;
		if ($urandom_range(4) == 0) begin
			// Exactly the limit magnitude, sometimes one past it.
			m = lim;
			while (m != 0) begin
				digs.push_front(int'(m % 64'(base)));
				m = m / 64'(base);
			end
			if ($urandom_range(2) == 0 && digs[digs.size()-1] < base - 1)
				digs[digs.size()-1]++;
			foreach (digs[i]) begin
				put(digit_char(digs[i]), lead);
				lead = 1'b0;
			end
		end else begin
			if ($urandom_range(3) == 0) begin
				// Lengths around the point of overflow.
				nd = 0;
				m = lim;
				while (m != 0) begin
					m = m / 64'(base);
					nd++;
				end
				n = nd - 1 + $urandom_range(3);
			end else begin
				n = $urandom_range(0, 6);
			end
			for (int i = 0; i < n; i++) begin
				put(digit_char($urandom_range(base - 1)), lead);
				lead = 1'b0;
			end
		end

		if ($urandom_range(9) != 0) begin
			case ($urandom_range(3))
				0: put(8'h00, lead);
				1: put(" ", lead);
				2: put(".", lead);
				default: put(8'($urandom_range(255)), lead);
			endcase
		end
		n = $urandom_range(0, 2);
		for (int i = 0; i < n; i++)
			put(8'($urandom_range(255)), 1'b0);
	endfunction

	// Offers one character until it is transferred.
	task automatic send_char(char_t it);
		bit done;
		done = 1'b0;
		while (!done) begin
			@(negedge clk);
			if (take_break()) begin
				push <= 1'b0;
			end else begin
				push <= 1'b1;
				ch <= it.c;
				first <= it.first;
				@(posedge clk);
				if (!full) begin
					tracker.take_char(it.c, it.first);
					done = 1'b1;
				end
			end
		end
	endtask

	task automatic flush_text();
		foreach (text[i])
			send_char(text[i]);
		text.delete();
	endtask

	task automatic drop_push();
		@(negedge clk);
		push <= 1'b0;
	endtask

	task automatic wait_results();
		while (tracker.pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Block is idle: every result is out and the pipeline has emptied.
	task automatic quiesce();
		wait_results();
		repeat (6) @(posedge clk);
	endtask

	task automatic write_radix(bit [RADIX_W-1:0] r);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= r;
		do @(posedge clk); while (!cfg_ready);
		tracker.radix = r;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Stimulus.
	initial begin
		bit [RADIX_W-1:0] radix_plan[12];
		int               sent;
		bit               paused;

		tracker = new();
		steady = 1'b0;
		arst_n = 1'b0;
		push = 1'b0;
		ch = '0;
		first = 1'b0;
		pop = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		radix_plan = '{RADIX_AUTO, BASE_HEX, 6'd2, BASE_MAX, BASE_OCT, BASE_DEC, 6'd63,
			RADIX_ONE, 6'd37, 6'd0, 6'd0, RADIX_AUTO};
		radix_plan[9] = RADIX_W'($urandom_range(63));
		radix_plan[10] = RADIX_W'($urandom_range(63));

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: a character while idle, blanks and a minus sign in base 10.
		put(8'h80, 1'b0);
		put_str(" -12", 1'b1);
		put(8'h00, 1'b0);
		flush_text();
		drop_push();

		// Auto base: octal zero with an x and no hex digit, ignored tail,
		// octal, and whitespace after a sign.
		quiesce();
		write_radix(RADIX_AUTO);
		put_str(" -0xg", 1'b1);
		put(8'hFF, 1'b0);
		put_str("017", 1'b1);
		put(8'h00, 1'b0);
		put_str("+\t", 1'b1);
		flush_text();
		drop_push();

		// Invalid base: nothing is a digit.
		quiesce();
		write_radix(RADIX_ONE);
		put_str("5", 1'b1);
		flush_text();
		drop_push();

		// Highest base, both letter cases.
		quiesce();
		write_radix(BASE_MAX);
		put_str("Zz", 1'b1);
		put(8'hFF, 1'b0);
		flush_text();
		drop_push();

		// Base 16 skips an 0X prefix.
		quiesce();
		write_radix(BASE_HEX);
		put_str("0XfF\n", 1'b1);
		flush_text();
		drop_push();

		// Random strings over a range of bases.
		foreach (radix_plan[p]) begin
			quiesce();
			write_radix(radix_plan[p]);
			steady = (p == 5);
			sent = 0;
			paused = 1'b0;
			while (sent < 60) begin
				make_string(radix_plan[p]);
				sent += text.size();
				flush_text();
				if (p == 2 && !paused && sent > 30) begin
					drop_push();
					wait_results();
					paused = 1'b1;
				end
			end
			drop_push();
			steady = 1'b0;
		end

		quiesce();
		repeat (4) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending_results.size() == 0)
			$display("string_to_int64_parser_top: match");
		else
			$display("string_to_int64_parser_top: mismatch");
		$finish;
	end

	// Hard limit on the run.
	initial begin
		#12_000_000;
		$display("string_to_int64_parser_top: mismatch");
		$finish;
	end

endmodule

/* sim.f */
rtl/s2i_pkg.sv
rtl/s2i_front.sv
rtl/s2i_back.sv
rtl/s2i_outq.sv
rtl/string_to_int64_parser_top.sv
verif/tb_string_to_int64_parser_top.sv
